/* rtl/rspt_pkg.sv */
// rspt_pkg: shared types and constants of the restricted shortest path table
package rspt_pkg;

  localparam int MAX_VERTICES = 512;
  localparam int VERT_W       = $clog2(MAX_VERTICES);
  localparam int ADDR_W       = 2 * VERT_W;
  localparam int MEM_DEPTH    = MAX_VERTICES * MAX_VERTICES;

  localparam int DIST_W       = 26;
  localparam int OUT_W        = 25;
  localparam int WEIGHT_W     = 16;
  localparam int VCNT_W       = 10;
  localparam int OP_W         = 2;

  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 32;
  localparam int CFG_DATA_W   = 16;

  localparam logic [DIST_W-1:0] DIST_INF   = {DIST_W{1'b1}};
  localparam logic [OUT_W-1:0]  OUT_MAX    = {OUT_W{1'b1}};
  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(512);
  localparam logic [VCNT_W-1:0] VCNT_MAX   = VCNT_W'(MAX_VERTICES);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_ACT   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QWAIT,
    ST_ACTCHK,
    ST_ROWRD,
    ST_ROWCHK,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [DIST_W-1:0] data;
  } rspt_wr_t;

endpackage

/* rtl/rspt_relax.sv */
// rspt_relax: min-plus relaxation of one matrix cell through the pivot vertex
module rspt_relax (
  input  logic                        valid,
  input  logic [rspt_pkg::DIST_W-1:0] ik,
  input  logic [rspt_pkg::DIST_W-1:0] kj,
  input  logic [rspt_pkg::DIST_W-1:0] ij,
  output rspt_pkg::rspt_wr_t          wr
);

  logic [rspt_pkg::DIST_W:0]   sum;
  logic [rspt_pkg::DIST_W-1:0] sum_sat;
  logic                        kj_ok;

  assign kj_ok   = (kj != rspt_pkg::DIST_INF);
  assign sum     = {1'b0, ik} + {1'b0, kj};
  // sums reaching infinity count as infinity
  assign sum_sat = (sum >= {1'b0, rspt_pkg::DIST_INF}) ? rspt_pkg::DIST_INF
                                                       : sum[rspt_pkg::DIST_W-1:0];

  assign wr.we   = valid && kj_ok && (sum_sat < ij);
  assign wr.data = sum_sat;

endmodule

/* rtl/restricted_shortest_path_table_core.sv */
// restricted_shortest_path_table_core: distance matrix with pivot sweeps and queries
//
// input channel in_*: one item per handshake, op in in_tuser, vertices and weight in
// in_tdata. add edge writes its weight into the matrix when taken; unknown ops are
// dropped. a query reads its cell, then waits in ST_QWAIT for the result register;
// its result leaves on out_* in the cycle after the register is loaded. an
// activation of a vertex not yet active sweeps the matrix through that vertex: a
// flag check in ST_ACTCHK, then per row ST_ROWRD and ST_ROWCHK fetch the pivot
// column entry, and ST_SWEEP relaxes the row's vertex_count cells when it is finite.
// config port cfg_*: writes vertex_count at any time, always ready.
// after reset the matrix memory is cleared one entry a cycle, 262144 entries, while
// in_tready stays low. the result register holds while out_tready is low; new items
// are still taken then, and only a further query waits for the register to drain.
module restricted_shortest_path_table_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rspt_pkg::IN_TDATA_W-1:0]     in_tdata,  // src_vertex, dst_vertex, edge_weight
  input  logic [rspt_pkg::OP_W-1:0]           in_tuser,  // op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rspt_pkg::OUT_TDATA_W-1:0]    out_tdata, // distance
  output logic                                out_tuser, // unreachable
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rspt_pkg::CFG_DATA_W-1:0]     cfg_data   // vertex_count
);

  localparam int VW = rspt_pkg::VERT_W;
  localparam int AW = rspt_pkg::ADDR_W;
  localparam int DW = rspt_pkg::DIST_W;

  // memories
  logic [DW-1:0] dist_mem [rspt_pkg::MEM_DEPTH];
  logic          act_mem  [rspt_pkg::MAX_VERTICES];

  rspt_pkg::state_t state_r, state_nxt;

  logic [VW-1:0]                 i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DW-1:0]                 ik_r, ik_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [rspt_pkg::VCNT_W-1:0]   vc_r, lim, lim_m1;
  logic                          pv_r;
  logic [AW-1:0]                 pa_r;
  logic [DW-1:0]                 rd_a_r, rd_b_r;
  logic                          act_rd_r;
  logic                          out_tvalid_r, out_tvalid_nxt, out_unr_r;
  logic [rspt_pkg::OUT_W-1:0]    out_dist_r;

  logic [AW-1:0]                 ra_a, ra_b, mem_wa;
  logic                          mem_we;
  logic [DW-1:0]                 mem_wd;
  logic [VW-1:0]                 flag_ra, flag_wa;
  logic                          flag_we, flag_wd;
  logic                          in_rdy, in_acc, out_load;
  logic                          i_last, j_last, clr_last;
  logic [VW-1:0]                 in_src, in_dst;
  logic [rspt_pkg::WEIGHT_W-1:0] in_w;
  rspt_pkg::op_t                 in_op;
  logic                          q_unr;
  logic [rspt_pkg::OUT_W-1:0]    q_dist;
  rspt_pkg::rspt_wr_t            rlx_wr;

  assign in_src   = in_tdata[VW-1:0];
  assign in_dst   = in_tdata[2*VW-1:VW];
  assign in_w     = in_tdata[2*VW +: rspt_pkg::WEIGHT_W];
  assign in_op    = rspt_pkg::op_t'(in_tuser);
  assign in_acc   = in_tvalid && in_rdy;
  assign in_tready = in_rdy;
  assign cfg_ready = 1'b1;

  assign lim      = (vc_r > rspt_pkg::VCNT_MAX) ? rspt_pkg::VCNT_MAX : vc_r;
  assign lim_m1   = lim - rspt_pkg::VCNT_W'(1);
  assign i_last   = ({1'b0, i_r} == lim_m1);
  assign j_last   = ({1'b0, j_r} == lim_m1);
  assign clr_last = &clr_r;

  assign q_unr    = (rd_a_r == rspt_pkg::DIST_INF);
  assign q_dist   = q_unr ? '0 :
                    ((rd_a_r > {1'b0, rspt_pkg::OUT_MAX}) ? rspt_pkg::OUT_MAX
                                                          : rd_a_r[rspt_pkg::OUT_W-1:0]);

  rspt_relax u_relax (
    .valid (pv_r),
    .ik    (ik_r),
    .kj    (rd_a_r),
    .ij    (rd_b_r),
    .wr    (rlx_wr)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rspt_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = rspt_pkg::ST_IDLE;
      end
      rspt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            rspt_pkg::OP_ACT:   state_nxt = rspt_pkg::ST_ACTCHK;
            rspt_pkg::OP_QUERY: state_nxt = rspt_pkg::ST_QWAIT;
            default:            state_nxt = rspt_pkg::ST_IDLE;
          endcase
        end
      end
      rspt_pkg::ST_QWAIT: begin
        if (out_load) state_nxt = rspt_pkg::ST_IDLE;
      end
      rspt_pkg::ST_ACTCHK: begin
        if (act_rd_r || lim == '0) state_nxt = rspt_pkg::ST_IDLE;
        else                       state_nxt = rspt_pkg::ST_ROWRD;
      end
      rspt_pkg::ST_ROWRD: state_nxt = rspt_pkg::ST_ROWCHK;
      rspt_pkg::ST_ROWCHK: begin
        if (rd_a_r != rspt_pkg::DIST_INF) state_nxt = rspt_pkg::ST_SWEEP;
        else if (i_last)                  state_nxt = rspt_pkg::ST_IDLE;
        else                              state_nxt = rspt_pkg::ST_ROWRD;
      end
      rspt_pkg::ST_SWEEP: begin
        if (j_last) state_nxt = i_last ? rspt_pkg::ST_IDLE : rspt_pkg::ST_ROWRD;
      end
      default: state_nxt = rspt_pkg::ST_CLEAR;
    endcase
  end

  // outputs, memory ports and counters
  always_comb begin
    in_rdy   = 1'b0;
    ra_a     = {i_r, k_r};
    ra_b     = {i_r, j_r};
    mem_we   = 1'b0;
    mem_wa   = pa_r;
    mem_wd   = rlx_wr.data;
    flag_ra  = in_src;
    flag_we  = 1'b0;
    flag_wa  = k_r;
    flag_wd  = 1'b1;
    out_load = 1'b0;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    ik_nxt   = ik_r;
    clr_nxt  = clr_r;
    if (pv_r && rlx_wr.we) mem_we = 1'b1;
    case (state_r)
      rspt_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = (clr_r[AW-1:VW] == clr_r[VW-1:0]) ? '0 : rspt_pkg::DIST_INF;
        flag_we = 1'b1;
        flag_wa = clr_r[VW-1:0];
        flag_wd = 1'b0;
        clr_nxt = clr_r + AW'(1);
      end
      rspt_pkg::ST_IDLE: begin
        in_rdy = !pv_r;
        ra_a   = {in_src, in_dst};
        if (in_acc) begin
          k_nxt = in_src;
          j_nxt = in_dst;
          i_nxt = '0;
          if (in_op == rspt_pkg::OP_ADD) begin
            mem_we = 1'b1;
            mem_wa = {in_src, in_dst};
            mem_wd = {{(DW-rspt_pkg::WEIGHT_W){1'b0}}, in_w};
          end
        end
      end
      rspt_pkg::ST_QWAIT: begin
        // keep reading the queried cell while the result register is full
        ra_a     = {k_r, j_r};
        out_load = !out_tvalid_r || out_tready;
      end
      rspt_pkg::ST_ACTCHK: begin
        flag_we = !act_rd_r;
      end
      rspt_pkg::ST_ROWRD: begin
        ra_a = {i_r, k_r};
      end
      rspt_pkg::ST_ROWCHK: begin
        j_nxt  = '0;
        ik_nxt = rd_a_r;
        if (rd_a_r == rspt_pkg::DIST_INF && !i_last) i_nxt = i_r + VW'(1);
      end
      rspt_pkg::ST_SWEEP: begin
        ra_a = {k_r, j_r};
        ra_b = {i_r, j_r};
        j_nxt = j_r + VW'(1);
        if (j_last && !i_last) i_nxt = i_r + VW'(1);
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  assign out_tvalid_nxt = out_load || (out_tvalid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (mem_we) dist_mem[mem_wa] <= mem_wd;
    rd_a_r <= dist_mem[ra_a];
    rd_b_r <= dist_mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (flag_we) act_mem[flag_wa] <= flag_wd;
    act_rd_r <= act_mem[flag_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rspt_pkg::ST_CLEAR;
      clr_r        <= '0;
      vc_r         <= rspt_pkg::VCNT_RESET;
      pv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      pv_r         <= (state_r == rspt_pkg::ST_SWEEP);
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) vc_r <= cfg_data[rspt_pkg::VCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    ik_r <= ik_nxt;
    pa_r <= {i_r, j_r};
    if (out_load) begin
      out_dist_r <= q_dist;
      out_unr_r  <= q_unr;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(rspt_pkg::OUT_TDATA_W-rspt_pkg::OUT_W){1'b0}}, out_dist_r};
  assign out_tuser  = out_unr_r;

`ifndef ASSERT_OFF
  a_no_accept_with_write: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> !in_tready) else $error("item accepted while a relax write is pending");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rspt_pkg::ST_CLEAR) |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_pivot_row_col_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r && rlx_wr.we) |-> (pa_r[AW-1:VW] != k_r && pa_r[VW-1:0] != k_r))
    else $error("sweep rewrote the pivot row or column");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == rspt_pkg::ST_QWAIT))
    else $error("result appeared without a query");

  a_unreachable_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("unreachable result carries a distance");
`endif

endmodule
